[rtl/ahc_pkg.sv]
// ----------------------------------------------------------------------------
// Allocation history checker package
// Event codes, history entry layout and default sizing shared by the block.
// ----------------------------------------------------------------------------
package ahc_pkg;

  localparam int HIST_SLOTS_DEFAULT = 64;

  localparam int ADDR_W  = 32;
  localparam int ALLOC_W = 2;
  localparam int OP_W    = 2;

  localparam logic [OP_W-1:0] OP_ALLOC   = 2'd0;
  localparam logic [OP_W-1:0] OP_REALLOC = 2'd1;
  localparam logic [OP_W-1:0] OP_FREE    = 2'd2;

  typedef struct packed {
    logic [ADDR_W-1:0]  addr;
    logic [ALLOC_W-1:0] alloc;
    logic [OP_W-1:0]    kind;
  } hist_entry_t;

  localparam int ENTRY_W = $bits(hist_entry_t);

endpackage

[rtl/alloc_history_checker_core.sv]
// ----------------------------------------------------------------------------
// Allocation history checker
// Keeps a sliding window of allocator events and flags leaks on eviction,
// double frees, wrong allocators, bad reallocs and allocs of live pointers.
// ----------------------------------------------------------------------------
// An event is taken when start is high and busy is low. The history sits in a
// circular buffer RAM with one read port; each event walks every valid entry
// once, oldest first, one entry per cycle, through a single address compare
// path. The result appears on the flag ports for one cycle with done high,
// after the walk over count entries (count = entries held before the event,
// at most HISTORY_SLOTS) and then the drain and finish states; with an empty
// window the walk and drain are skipped. The receiver cannot stall the
// result. check_enable may be written with cfg_we whenever busy is low and
// no result is pending; with it clear the history is still kept but all
// warning flags read zero.
// ----------------------------------------------------------------------------
module alloc_history_checker_core #(
  parameter int HISTORY_SLOTS = ahc_pkg::HIST_SLOTS_DEFAULT
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_we,
  input  logic                         cfg_wdata,
  input  logic                         start,
  output logic                         busy,
  input  logic [ahc_pkg::ADDR_W-1:0]   address,
  input  logic [ahc_pkg::ALLOC_W-1:0]  allocator_id,
  input  logic [ahc_pkg::OP_W-1:0]     op,
  output logic                         done,
  output logic                         double_free,
  output logic                         wrong_allocator,
  output logic                         realloc_untracked,
  output logic                         realloc_of_freed,
  output logic                         alloc_while_live,
  output logic                         leak_on_evict,
  output logic [ahc_pkg::ADDR_W-1:0]   evicted_address,
  output logic                         window_shifted,
  output logic                         fatal
);

  import ahc_pkg::*;

  localparam int PW = $clog2(HISTORY_SLOTS);
  localparam int CW = $clog2(HISTORY_SLOTS + 1);

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_WALK   = 2'd1;
  localparam logic [1:0] S_DRAIN  = 2'd2;
  localparam logic [1:0] S_FINISH = 2'd3;

  function automatic logic [PW-1:0] wrap_inc(input logic [PW-1:0] p);
    wrap_inc = (p == PW'(HISTORY_SLOTS - 1)) ? '0 : p + 1'b1;
  endfunction

  logic [1:0]         state;
  logic               check_enable;
  logic [PW-1:0]      head;
  logic [CW-1:0]      count;
  logic [PW-1:0]      rd_ptr;
  logic [PW-1:0]      iss_idx;
  logic               dv;
  logic [PW-1:0]      d_idx;

  logic [ADDR_W-1:0]  in_addr;
  logic [ALLOC_W-1:0] in_alloc;
  logic [OP_W-1:0]    in_op;
  logic               en;
  logic               full;

  logic [ADDR_W-1:0]  ev_addr;
  logic               ev_nonfree;
  logic               later_free;
  logic               pa_found;
  logic [PW-1:0]      pa_pos;
  logic [ALLOC_W-1:0] pa_alloc;
  logic               pf_found;
  logic [PW-1:0]      pf_pos;
  logic               pr_found;
  logic [PW-1:0]      pr_pos;

  logic [ENTRY_W-1:0] rdata;
  hist_entry_t        ent;
  hist_entry_t        new_ent;

  logic df_next, wa_next, ru_next, rf_next, al_next, leak_next;
  logic free_newer;

  assign busy = (state != S_IDLE);
  assign ent  = hist_entry_t'(rdata);

  assign new_ent.addr  = in_addr;
  assign new_ent.alloc = in_alloc;
  assign new_ent.kind  = in_op;

  // write the new word into the slot just past the walk: the tail, or the
  // evicted head when the window is full
  ahc_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(HISTORY_SLOTS)
  ) u_hist (
    .clk  (clk),
    .we   (state == S_FINISH),
    .waddr(rd_ptr),
    .wdata(new_ent),
    .re   (state == S_WALK),
    .raddr(rd_ptr),
    .rdata(rdata)
  );

  always_comb begin
    free_newer = pf_found && (!pa_found || (pf_pos > pa_pos));
    df_next    = en && (in_op == OP_FREE) && free_newer;
    wa_next    = en && ((in_op == OP_FREE) || (in_op == OP_REALLOC)) && pa_found &&
                 (pa_alloc != in_alloc);
    ru_next    = en && (in_op == OP_REALLOC) && !pa_found;
    rf_next    = en && (in_op == OP_REALLOC) && free_newer;
    al_next    = en && (in_op == OP_ALLOC) && pa_found &&
                 (!pf_found || (pa_pos > pf_pos) || !pr_found || (pa_pos > pr_pos));
    leak_next  = en && full && ev_nonfree && !later_free;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      check_enable <= 1'b0;
      head         <= '0;
      count        <= '0;
      dv           <= 1'b0;
      done         <= 1'b0;
    end else begin
      if (cfg_we) begin
        check_enable <= cfg_wdata;
      end
      done <= 1'b0;
      dv   <= 1'b0;

      unique case (state)
        S_IDLE: begin
          if (start) begin
            in_addr    <= address;
            in_alloc   <= allocator_id;
            in_op      <= op;
            en         <= check_enable;
            full       <= (count == CW'(HISTORY_SLOTS));
            rd_ptr     <= head;
            iss_idx    <= '0;
            later_free <= 1'b0;
            pa_found   <= 1'b0;
            pf_found   <= 1'b0;
            pr_found   <= 1'b0;
            state      <= (count == '0) ? S_FINISH : S_WALK;
          end
        end
        S_WALK: begin
          dv      <= 1'b1;
          d_idx   <= iss_idx;
          rd_ptr  <= wrap_inc(rd_ptr);
          iss_idx <= iss_idx + 1'b1;
          if (CW'(iss_idx) == count - 1'b1) begin
            state <= S_DRAIN;
          end
        end
        S_DRAIN: begin
          state <= S_FINISH;
        end
        S_FINISH: begin
          double_free       <= df_next;
          wrong_allocator   <= wa_next;
          realloc_untracked <= ru_next;
          realloc_of_freed  <= rf_next;
          alloc_while_live  <= al_next;
          leak_on_evict     <= leak_next;
          evicted_address   <= full ? ev_addr : '0;
          window_shifted    <= full;
          fatal             <= df_next | wa_next | rf_next | al_next;
          done              <= 1'b1;
          if (full) begin
            head <= wrap_inc(head);
          end else begin
            count <= count + 1'b1;
          end
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase

      // one history word per cycle; later matches overwrite earlier ones
      if (dv) begin
        if (full && (d_idx == '0)) begin
          ev_addr    <= ent.addr;
          ev_nonfree <= (ent.kind != OP_FREE);
        end else begin
          if (full && (ent.addr == ev_addr) && (ent.kind == OP_FREE)) begin
            later_free <= 1'b1;
          end
          if (ent.addr == in_addr) begin
            case (ent.kind)
              OP_ALLOC: begin
                pa_found <= 1'b1;
                pa_pos   <= d_idx;
                pa_alloc <= ent.alloc;
              end
              OP_FREE: begin
                pf_found <= 1'b1;
                pf_pos   <= d_idx;
              end
              OP_REALLOC: begin
                pr_found <= 1'b1;
                pr_pos   <= d_idx;
              end
              default: begin
              end
            endcase
          end
        end
      end
    end
  end

endmodule

[rtl/ahc_ram.sv]
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module ahc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[tb/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Allocation history checker testbench
// Sends allocator events through the start/busy port and predicts each result
// from a software copy of the history window. Results are checked field by
// field against the predicted ones, in order. The run covers directed misuse
// cases, then random alloc/realloc/free lifecycles with noise and abandoned
// pointers, with the check enable both on and off.
// ----------------------------------------------------------------------------
module testbench;

  localparam int SLOTS       = ahc_pkg::HIST_SLOTS_DEFAULT;
  localparam int POOL_SIZE   = 6;
  localparam int QUIET_LIMIT = 4000;
  localparam logic [ahc_pkg::OP_W-1:0] OP_UNKNOWN = 2'd3;

  typedef struct packed {
    logic                       double_free;
    logic                       wrong_allocator;
    logic                       realloc_untracked;
    logic                       realloc_of_freed;
    logic                       alloc_while_live;
    logic                       leak_on_evict;
    logic [ahc_pkg::ADDR_W-1:0] evicted_address;
    logic                       window_shifted;
    logic                       fatal;
  } verdict_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic cfg_wdata = 1'b0;
  logic start = 1'b0;
  logic [ahc_pkg::ADDR_W-1:0]  address = '0;
  logic [ahc_pkg::ALLOC_W-1:0] allocator_id = '0;
  logic [ahc_pkg::OP_W-1:0]    op = '0;
  logic busy;
  logic done;
  logic double_free;
  logic wrong_allocator;
  logic realloc_untracked;
  logic realloc_of_freed;
  logic alloc_while_live;
  logic leak_on_evict;
  logic [ahc_pkg::ADDR_W-1:0] evicted_address;
  logic window_shifted;
  logic fatal;

  // predictor state
  ahc_pkg::hist_entry_t window_q[$];
  bit                   chk_en = 1'b0;

  ahc_pkg::hist_entry_t pending_events[$];
  verdict_t             verdict_q[$];
  int                   idle_pct = 24;
  int                   mismatches = 0;
  int                   events_sent = 0;
  int                   results_seen = 0;
  int                   fatal_seen = 0;
  int                   leaks_seen = 0;
  int                   shifts_seen = 0;
  int                   quiet_cycles = 0;

  // generator pool: addresses that go through alloc/realloc/free lifecycles
  logic [ahc_pkg::ADDR_W-1:0]  pool_addr[POOL_SIZE];
  logic [ahc_pkg::ALLOC_W-1:0] pool_owner[POOL_SIZE];
  bit                          pool_live[POOL_SIZE];

  alloc_history_checker_core u_dut (
    .clk               (clk),
    .rst               (rst),
    .cfg_we            (cfg_we),
    .cfg_wdata         (cfg_wdata),
    .start             (start),
    .busy              (busy),
    .address           (address),
    .allocator_id      (allocator_id),
    .op                (op),
    .done              (done),
    .double_free       (double_free),
    .wrong_allocator   (wrong_allocator),
    .realloc_untracked (realloc_untracked),
    .realloc_of_freed  (realloc_of_freed),
    .alloc_while_live  (alloc_while_live),
    .leak_on_evict     (leak_on_evict),
    .evicted_address   (evicted_address),
    .window_shifted    (window_shifted),
    .fatal             (fatal)
  );

  always #6 clk = ~clk;

  // Position plus one of the newest entry in the window with this address and
  // kind, 0 if none.
  function automatic int newest_match(input logic [ahc_pkg::ADDR_W-1:0] a,
                                      input logic [ahc_pkg::OP_W-1:0] k);
    int i;
    for (i = window_q.size() - 1; i >= 0; i--)
      if (window_q[i].addr == a && window_q[i].kind == k)
        return i + 1;
    return 0;
  endfunction

  function automatic verdict_t judge_event(input logic [ahc_pkg::ADDR_W-1:0] a,
                                           input logic [ahc_pkg::ALLOC_W-1:0] id,
                                           input logic [ahc_pkg::OP_W-1:0] k);
    verdict_t v;
    bit freed_later;
    int pf;
    int pa;
    int pr;
    ahc_pkg::hist_entry_t e;
    v = '0;
    if (window_q.size() >= SLOTS) begin
      v.window_shifted = 1'b1;
      v.evicted_address = window_q[0].addr;
      if (chk_en && window_q[0].kind != ahc_pkg::OP_FREE) begin
        freed_later = 1'b0;
        for (int i = 1; i < window_q.size(); i++)
          if (window_q[i].addr == window_q[0].addr && window_q[i].kind == ahc_pkg::OP_FREE)
            freed_later = 1'b1;
        v.leak_on_evict = !freed_later;
      end
      void'(window_q.pop_front());
    end
    // search the window as it stands before the new entry goes in
    pf = newest_match(a, ahc_pkg::OP_FREE);
    pa = newest_match(a, ahc_pkg::OP_ALLOC);
    pr = newest_match(a, ahc_pkg::OP_REALLOC);
    if (chk_en) begin
      if (k == ahc_pkg::OP_FREE && pf != 0 && pf > pa)
        v.double_free = 1'b1;
      if ((k == ahc_pkg::OP_FREE || k == ahc_pkg::OP_REALLOC) && pa != 0 &&
          window_q[pa-1].alloc != id)
        v.wrong_allocator = 1'b1;
      if (k == ahc_pkg::OP_REALLOC && pa == 0)
        v.realloc_untracked = 1'b1;
      if (k == ahc_pkg::OP_REALLOC && pf != 0 && pf > pa)
        v.realloc_of_freed = 1'b1;
      if (k == ahc_pkg::OP_ALLOC && pa != 0 && (pa > pf || pa > pr))
        v.alloc_while_live = 1'b1;
    end
    e.addr = a;
    e.alloc = id;
    e.kind = k;
    window_q.push_back(e);
    v.fatal = v.double_free | v.wrong_allocator | v.realloc_of_freed | v.alloc_while_live;
    return v;
  endfunction

  task automatic queue_event(input logic [ahc_pkg::ADDR_W-1:0] a,
                             input logic [ahc_pkg::ALLOC_W-1:0] id,
                             input logic [ahc_pkg::OP_W-1:0] k);
    ahc_pkg::hist_entry_t e;
    e.addr = a;
    e.alloc = id;
    e.kind = k;
    pending_events.push_back(e);
  endtask

  // Mostly well-formed lifecycles on a small address pool, some abandoned
  // pointers (they leak on eviction), the rest random noise.
  task automatic queue_lifecycles(input int count);
    int slot;
    for (int n = 0; n < count; n++) begin
      slot = $urandom_range(POOL_SIZE - 1);
      if ($urandom_range(99) < 80) begin
        if (!pool_live[slot]) begin
          if ($urandom_range(3) == 0)
            pool_addr[slot] = $urandom;
          pool_owner[slot] = 2'($urandom_range(3));
          pool_live[slot] = 1'b1;
          queue_event(pool_addr[slot], pool_owner[slot], ahc_pkg::OP_ALLOC);
        end else if ($urandom_range(99) < 10) begin
          pool_addr[slot] = $urandom;
          pool_owner[slot] = 2'($urandom_range(3));
          queue_event(pool_addr[slot], pool_owner[slot], ahc_pkg::OP_ALLOC);
        end else if ($urandom_range(99) < 35) begin
          queue_event(pool_addr[slot], pool_owner[slot], ahc_pkg::OP_REALLOC);
        end else begin
          pool_live[slot] = 1'b0;
          queue_event(pool_addr[slot], pool_owner[slot], ahc_pkg::OP_FREE);
        end
      end else begin
        queue_event($urandom_range(1) ? pool_addr[slot] : $urandom,
                    2'($urandom_range(3)), 2'($urandom_range(3)));
      end
    end
  endtask

  task automatic drain;
    while (pending_events.size() != 0 || verdict_q.size() != 0 || start)
      @(posedge clk);
  endtask

  task automatic write_check_enable(input bit v);
    drain();
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    chk_en = v;
  endtask

  task automatic check_field(input string name, input logic [31:0] want_v,
                             input logic [31:0] got_v);
    if (got_v !== want_v) begin
      $error("%s: expected %0h, got %0h", name, want_v, got_v);
      mismatches++;
    end
  endtask

  // Driver: hold the word until busy drops, then advance or idle.
  always @(posedge clk) begin : drive_proc
    ahc_pkg::hist_entry_t ev;
    if (!rst) begin
      if (start && !busy) begin
        verdict_q.push_back(judge_event(address, allocator_id, op));
        events_sent++;
      end
      if ((!start || !busy) && pending_events.size() != 0 &&
          $urandom_range(99) >= idle_pct) begin
        ev = pending_events.pop_front();
        start <= 1'b1;
        address <= ev.addr;
        allocator_id <= ev.alloc;
        op <= ev.kind;
      end else if (start && !busy) begin
        start <= 1'b0;
      end
    end
  end

  // Monitor: every done strobe must match the oldest prediction.
  always @(posedge clk) begin : watch_proc
    verdict_t want;
    if (!rst && done) begin
      results_seen++;
      if (verdict_q.size() == 0) begin
        $error("result word with no event outstanding");
        mismatches++;
      end else begin
        want = verdict_q.pop_front();
        check_field("double_free", 32'(want.double_free), 32'(double_free));
        check_field("wrong_allocator", 32'(want.wrong_allocator), 32'(wrong_allocator));
        check_field("realloc_untracked", 32'(want.realloc_untracked),
                    32'(realloc_untracked));
        check_field("realloc_of_freed", 32'(want.realloc_of_freed), 32'(realloc_of_freed));
        check_field("alloc_while_live", 32'(want.alloc_while_live), 32'(alloc_while_live));
        check_field("leak_on_evict", 32'(want.leak_on_evict), 32'(leak_on_evict));
        check_field("evicted_address", want.evicted_address, evicted_address);
        check_field("window_shifted", 32'(want.window_shifted), 32'(window_shifted));
        check_field("fatal", 32'(want.fatal), 32'(fatal));
        fatal_seen += int'(want.fatal);
        leaks_seen += int'(want.leak_on_evict);
        shifts_seen += int'(want.window_shifted);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (start && !busy) || done) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("watchdog: no traffic for %0d cycles", QUIET_LIMIT);
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    for (int i = 0; i < POOL_SIZE; i++) begin
      pool_addr[i] = $urandom;
      pool_owner[i] = '0;
      pool_live[i] = 1'b0;
    end
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // enable is clear out of reset: an alloc-alloc-free-free sequence flags nothing
    queue_event(32'h1234_5678, 2'd1, ahc_pkg::OP_ALLOC);
    queue_event(32'h1234_5678, 2'd1, ahc_pkg::OP_ALLOC);
    queue_event(32'h1234_5678, 2'd2, ahc_pkg::OP_FREE);
    queue_event(32'h1234_5678, 2'd2, ahc_pkg::OP_FREE);
    write_check_enable(1'b1);

    queue_event(32'h0000_0000, 2'd0, ahc_pkg::OP_ALLOC);
    queue_event(32'h0000_0000, 2'd0, ahc_pkg::OP_ALLOC);   // alloc of live pointer
    queue_event(32'h0000_0000, 2'd1, ahc_pkg::OP_REALLOC); // wrong allocator
    queue_event(32'h0000_0000, 2'd0, ahc_pkg::OP_FREE);
    queue_event(32'h0000_0000, 2'd0, ahc_pkg::OP_FREE);    // double free
    queue_event(32'h0000_0000, 2'd0, ahc_pkg::OP_REALLOC); // realloc of freed
    queue_event(32'hFFFF_FFFF, 2'd3, ahc_pkg::OP_REALLOC); // untracked realloc
    queue_event(32'hA5A5_5A5A, 2'd2, ahc_pkg::OP_FREE);    // free with no alloc
    queue_event(32'hA5A5_5A5A, 2'd2, ahc_pkg::OP_FREE);
    queue_event(32'h0000_0000, 2'd1, OP_UNKNOWN);          // stored, never matched
    queue_event(32'h5A5A_A5A5, 2'd3, ahc_pkg::OP_ALLOC);
    queue_event(32'h5A5A_A5A5, 2'd3, ahc_pkg::OP_REALLOC);
    queue_event(32'h5A5A_A5A5, 2'd3, ahc_pkg::OP_ALLOC);
    queue_event(32'h0F0F_F0F0, 2'd0, ahc_pkg::OP_ALLOC);
    queue_event(32'h0F0F_F0F0, 2'd1, ahc_pkg::OP_FREE);    // wrong allocator
    queue_event(32'h0F0F_F0F0, 2'd2, ahc_pkg::OP_FREE);    // several flags at once
    queue_event(32'hFFFF_FFFF, 2'd3, OP_UNKNOWN);

    queue_lifecycles(700);
    write_check_enable(1'b0);
    queue_lifecycles(300);
    write_check_enable(1'b1);
    // back-to-back stretch with no idling
    drain();
    idle_pct = 0;
    queue_lifecycles(400);
    drain();
    repeat (SLOTS + 8) @(posedge clk);

    $display("sent %0d events, checked %0d results", events_sent, results_seen);
    $display("fatal results %0d, leaks on eviction %0d, window shifts %0d",
             fatal_seen, leaks_seen, shifts_seen);
    if (mismatches == 0 && verdict_q.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

[filelist.f]
rtl/ahc_pkg.sv
rtl/ahc_ram.sv
rtl/alloc_history_checker_core.sv
tb/testbench.sv
